// ===== src/mcc_pkg.sv =====
// shared types and constants for the minimum coin change core
`default_nettype none
package mcc_pkg;

  parameter int COIN_W         = 10;
  parameter int AMT_W          = 10;
  parameter int MIN_W          = 10;
  parameter int MAX_COINS_DEF  = 16;
  parameter int MAX_AMOUNT_DEF = 1023;

  parameter logic [MIN_W-1:0] MIN_COINS_MAX = 10'd1023;

  typedef struct packed {
    logic [COIN_W-1:0] coin_value;
    logic              coin_last;
    logic [AMT_W-1:0]  target_amount;
  } request_t;

  typedef struct packed {
    logic [MIN_W-1:0] min_coins;
    logic             unreachable;
    logic             coin_overflow;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEED,
    ST_SCAN,
    ST_STORE
  } state_t;

endpackage
`default_nettype wire

// ===== src/mcc_coin_store.sv =====
// coin denomination store with registered read
`default_nettype none
module mcc_coin_store #(
  parameter int MAX_COINS = mcc_pkg::MAX_COINS_DEF,
  parameter int IW        = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [IW-1:0]             waddr,
  input  wire logic [mcc_pkg::COIN_W-1:0] wdata,
  input  wire logic [IW-1:0]             raddr,
  output logic      [mcc_pkg::COIN_W-1:0] rdata
);

  logic [mcc_pkg::COIN_W-1:0] mem [MAX_COINS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/mcc_best_table.sv =====
// fewest-coins table memory, one write and one registered read per cycle
`default_nettype none
module mcc_best_table #(
  parameter int MAX_AMOUNT = mcc_pkg::MAX_AMOUNT_DEF,
  parameter int AW         = $clog2(MAX_AMOUNT + 1),
  parameter int EW         = AW + 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [EW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [EW-1:0] rdata
);

  logic [EW-1:0] mem [MAX_AMOUNT + 1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/min_coin_change_dp_core.sv =====
// top level: coin loading, table sweep sequencer and shared compare unit
//
// Coins arrive one request each (start high while busy is low) and each is
// taken in the cycle it is offered. The request with coin_last set starts the
// table sweep for an amount in range; the core stays busy while, for each
// partial sum, it does one table read and one compare per stored coin, then
// drains the pipeline and writes the entry back. A zero or too-large amount
// gives its result the cycle after the request. The result appears on result
// with done high for exactly one cycle; there is no way to hold it off, so it
// must be captured then. The table needs no clearing: every entry is written
// before it is read within one sweep.
`default_nettype none
module min_coin_change_dp_core #(
  parameter int MAX_COINS  = mcc_pkg::MAX_COINS_DEF,
  parameter int MAX_AMOUNT = mcc_pkg::MAX_AMOUNT_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire mcc_pkg::request_t request,
  output logic                   done,
  output mcc_pkg::result_t       result
);

  localparam int AW  = $clog2(MAX_AMOUNT + 1);
  localparam int CW  = AW;
  localparam int EW  = CW + 1;
  localparam int CNW = $clog2(MAX_COINS + 1);
  localparam int IW  = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;
  localparam int SW  = ((AW > mcc_pkg::COIN_W) ? AW : mcc_pkg::COIN_W) + 1;

  mcc_pkg::state_t state, state_next;

  logic [CNW-1:0] coin_count, coin_count_next;
  logic           overflow_seen, overflow_seen_next;
  logic [CNW-1:0] n_coins, n_coins_next;
  logic [AW-1:0]  amt, amt_next;
  logic [AW-1:0]  row, row_next;
  logic [CNW-1:0] j, j_next;
  logic           v1, v1_next;
  logic           ok2, ok2_next;
  logic           best_valid, best_valid_next;
  logic [CW-1:0]  best_cnt, best_cnt_next;
  logic           done_next;
  mcc_pkg::result_t result_next;

  logic                       accept;
  logic                       full;
  logic                       ovf;
  logic                       amt_zero;
  logic                       amt_big;
  logic                       issue;
  logic                       scan_end;
  logic                       store_we;
  logic [mcc_pkg::COIN_W-1:0] coin_q;
  logic [SW-1:0]              sum;
  logic                       sum_ok;
  logic                       tbl_we;
  logic [AW-1:0]              tbl_waddr;
  logic [EW-1:0]              tbl_wdata;
  logic [AW-1:0]              tbl_raddr;
  logic [EW-1:0]              tbl_rdata;
  logic [CW:0]                cand;
  logic                       better;
  logic [mcc_pkg::MIN_W-1:0]  sat_cnt;

  assign busy     = (state != mcc_pkg::ST_IDLE);
  assign accept   = start && !busy;
  assign full     = (coin_count == CNW'(MAX_COINS));
  assign ovf      = overflow_seen | full;
  assign amt_zero = (request.target_amount == '0);
  assign amt_big  = (int'(request.target_amount) > MAX_AMOUNT);
  assign store_we = accept && !full;
  assign issue    = (state == mcc_pkg::ST_SCAN) && (j < n_coins);
  assign scan_end = (j == n_coins) && !v1;

  // address of the partial sum reached by the coin just read
  assign sum       = SW'(row) + SW'(coin_q);
  assign sum_ok    = (coin_q != '0) && (sum <= SW'(amt));
  assign tbl_raddr = sum_ok ? sum[AW-1:0] : '0;

  // shared compare unit
  assign cand   = {1'b0, tbl_rdata[CW-1:0]} + (CW+1)'(1);
  assign better = ok2 && tbl_rdata[EW-1] && (!best_valid || (cand < {1'b0, best_cnt}));

  assign sat_cnt = (int'(best_cnt) > int'(mcc_pkg::MIN_COINS_MAX)) ?
                   mcc_pkg::MIN_COINS_MAX : mcc_pkg::MIN_W'(best_cnt);

  mcc_coin_store #(
    .MAX_COINS (MAX_COINS),
    .IW        (IW)
  ) u_coin_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (coin_count[IW-1:0]),
    .wdata (request.coin_value),
    .raddr (j[IW-1:0]),
    .rdata (coin_q)
  );

  mcc_best_table #(
    .MAX_AMOUNT (MAX_AMOUNT),
    .AW         (AW),
    .EW         (EW)
  ) u_best_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      mcc_pkg::ST_IDLE: begin
        if (accept && request.coin_last && !amt_zero && !amt_big) begin
          state_next = mcc_pkg::ST_SEED;
        end
      end
      mcc_pkg::ST_SEED: begin
        state_next = mcc_pkg::ST_SCAN;
      end
      mcc_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_next = mcc_pkg::ST_STORE;
        end
      end
      mcc_pkg::ST_STORE: begin
        state_next = (row == '0) ? mcc_pkg::ST_IDLE : mcc_pkg::ST_SCAN;
      end
      default: begin
        state_next = mcc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    coin_count_next    = coin_count;
    overflow_seen_next = overflow_seen;
    n_coins_next       = n_coins;
    amt_next           = amt;
    row_next           = row;
    j_next             = j;
    v1_next            = issue;
    ok2_next           = v1 && sum_ok;
    best_valid_next    = best_valid;
    best_cnt_next      = best_cnt;
    done_next          = 1'b0;
    result_next        = result;
    tbl_we             = 1'b0;
    tbl_waddr          = row;
    tbl_wdata          = {best_valid, best_cnt};

    if (better) begin
      best_valid_next = 1'b1;
      best_cnt_next   = cand[CW-1:0];
    end

    case (state)
      mcc_pkg::ST_IDLE: begin
        if (accept) begin
          coin_count_next    = full ? coin_count : coin_count + CNW'(1);
          overflow_seen_next = ovf;
          if (request.coin_last) begin
            n_coins_next              = full ? coin_count : coin_count + CNW'(1);
            coin_count_next           = '0;
            overflow_seen_next        = 1'b0;
            amt_next                  = AW'(request.target_amount);
            result_next.min_coins     = '0;
            result_next.unreachable   = amt_big && !amt_zero;
            result_next.coin_overflow = ovf;
            done_next                 = amt_zero || amt_big;
          end
        end
      end
      mcc_pkg::ST_SEED: begin
        tbl_we          = 1'b1;
        tbl_waddr       = amt;
        tbl_wdata       = {1'b1, CW'(0)};
        row_next        = amt - AW'(1);
        j_next          = '0;
        best_valid_next = 1'b0;
        best_cnt_next   = '0;
      end
      mcc_pkg::ST_SCAN: begin
        if (issue) begin
          j_next = j + CNW'(1);
        end
      end
      mcc_pkg::ST_STORE: begin
        tbl_we = 1'b1;
        if (row == '0) begin
          done_next               = 1'b1;
          result_next.min_coins   = best_valid ? sat_cnt : '0;
          result_next.unreachable = !best_valid;
        end else begin
          row_next        = row - AW'(1);
          j_next          = '0;
          best_valid_next = 1'b0;
          best_cnt_next   = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= mcc_pkg::ST_IDLE;
      coin_count    <= '0;
      overflow_seen <= 1'b0;
      j             <= '0;
      v1            <= 1'b0;
      ok2           <= 1'b0;
      done          <= 1'b0;
    end else begin
      state         <= state_next;
      coin_count    <= coin_count_next;
      overflow_seen <= overflow_seen_next;
      j             <= j_next;
      v1            <= v1_next;
      ok2           <= ok2_next;
      done          <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    n_coins    <= n_coins_next;
    amt        <= amt_next;
    row        <= row_next;
    best_valid <= best_valid_next;
    best_cnt   <= best_cnt_next;
    result     <= result_next;
  end

endmodule
`default_nettype wire

// ===== src/mcc_checker.sv =====
// port-level checks for the minimum coin change core, bound to the top level
`default_nettype none
module mcc_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire mcc_pkg::request_t request,
  input wire logic              done,
  input wire mcc_pkg::result_t  result
);

  // a coin that is not the last one never produces a result
  a_no_result_mid_set: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !request.coin_last) |=> !done)
    else $error("result after a non-final coin");

  // a zero amount gives zero coins at once
  a_zero_amount: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && request.coin_last && (request.target_amount == '0))
    |=> (done && (result.min_coins == '0) && !result.unreachable))
    else $error("zero amount not answered with zero coins");

  // unreachable results carry a zero count
  a_unreach_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.unreachable) |-> (result.min_coins == '0))
    else $error("unreachable result with nonzero count");

  // the core is free again when a result is shown
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  // a sweep only starts on a final coin request
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && request.coin_last))
    else $error("busy without a final coin request");

endmodule

bind min_coin_change_dp_core mcc_checker u_mcc_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .request (request),
  .done    (done),
  .result  (result)
);
`default_nettype wire

// ===== tb/min_coin_change_dp_checker.sv =====
// checker: predicts the fewest-coin result of each coin set and compares it with the core output
`default_nettype none
module min_coin_change_dp_checker (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic              busy,
  input  wire mcc_pkg::request_t request,
  input  wire logic              done,
  input  wire mcc_pkg::result_t  result,
  output int                     fail_count,
  output int                     pending
);

  localparam int DEPTH     = mcc_pkg::MAX_COINS_DEF;
  localparam int AMT_LIMIT = mcc_pkg::MAX_AMOUNT_DEF;

  logic [mcc_pkg::COIN_W-1:0] coin_bank [DEPTH];
  int                         coin_total;
  bit                         dropped;
  int                         fewest [AMT_LIMIT+1];
  bit                         reachable [AMT_LIMIT+1];
  mcc_pkg::result_t           expected_results [$];
  int                         errors;

  function automatic mcc_pkg::result_t fewest_coins(input int amt);
    mcc_pkg::result_t r;
    r = '0;
    r.coin_overflow = dropped;
    if (amt == 0) return r;
    if (amt > AMT_LIMIT) begin
      r.unreachable = 1'b1;
      return r;
    end
    fewest[amt] = 0;
    reachable[amt] = 1'b1;
    for (int k = amt - 1; k >= 0; k--) begin
      fewest[k] = 0;
      reachable[k] = 1'b0;
      for (int j = 0; j < coin_total; j++) begin
        int s;
        s = k + int'(coin_bank[j]);
        if (s <= amt && reachable[s]) begin
          if (!reachable[k] || fewest[s] + 1 < fewest[k]) begin
            fewest[k] = fewest[s] + 1;
            reachable[k] = 1'b1;
          end
        end
      end
    end
    if (!reachable[0]) r.unreachable = 1'b1;
    else if (fewest[0] > int'(mcc_pkg::MIN_COINS_MAX)) r.min_coins = mcc_pkg::MIN_COINS_MAX;
    else r.min_coins = fewest[0][mcc_pkg::MIN_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    mcc_pkg::result_t exp_r;
    if (rst) begin
      coin_total = 0;
      dropped = 1'b0;
      expected_results.delete();
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          $error("result with no request waiting: min_coins %0d", result.min_coins);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (result.min_coins !== exp_r.min_coins) begin
            $error("min_coins expected %0d got %0d", exp_r.min_coins, result.min_coins);
            errors++;
          end
          if (result.unreachable !== exp_r.unreachable) begin
            $error("unreachable expected %0d got %0d", exp_r.unreachable, result.unreachable);
            errors++;
          end
          if (result.coin_overflow !== exp_r.coin_overflow) begin
            $error("coin_overflow expected %0d got %0d", exp_r.coin_overflow,
                   result.coin_overflow);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        if (coin_total < DEPTH) begin
          coin_bank[coin_total] = request.coin_value;
          coin_total++;
        end else begin
          dropped = 1'b1;
        end
        if (request.coin_last) begin
          expected_results.push_back(fewest_coins(int'(request.target_amount)));
          coin_total = 0;
          dropped = 1'b0;
        end
      end
    end
    pending <= expected_results.size();
    fail_count <= errors;
  end

endmodule
`default_nettype wire

// ===== tb/min_coin_change_dp_core_tb.sv =====
// testbench top: drives coin sets into the minimum coin change core and reports the verdict
`default_nettype none
module min_coin_change_dp_core_tb;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  mcc_pkg::request_t request = '0;
  logic              busy;
  logic              done;
  mcc_pkg::result_t  result;
  int                fail_count;
  int                pending;
  int                items_sent;

  min_coin_change_dp_core uut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  min_coin_change_dp_checker result_check (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .request    (request),
    .done       (done),
    .result     (result),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #1000000000;
    $display("min_coin_change_dp_core_tb failed");
    $finish;
  end

  task automatic send_request(input logic [mcc_pkg::COIN_W-1:0] coin, input logic last,
                              input logic [mcc_pkg::AMT_W-1:0] amt);
    start <= 1'b1;
    request <= '{coin_value: coin, coin_last: last, target_amount: amt};
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic hold_off(input int cycles);
    logic [$bits(mcc_pkg::request_t)-1:0] junk;
    junk = $bits(mcc_pkg::request_t)'($urandom);
    start <= 1'b0;
    request <= junk;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic send_set(input int n, input int amt, input int coin_hi, input bit gaps);
    logic [mcc_pkg::COIN_W-1:0] coin;
    logic [mcc_pkg::AMT_W-1:0]  amt_field;
    int                         pick;
    for (int i = 0; i < n; i++) begin
      if (gaps && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 11));
      pick = $urandom_range(0, 99);
      if (pick < 5) coin = '0;
      else if (pick < 25) coin = mcc_pkg::COIN_W'($urandom_range(1, 1023));
      else coin = mcc_pkg::COIN_W'($urandom_range(1, coin_hi));
      if (i == n - 1) amt_field = mcc_pkg::AMT_W'(amt);
      else amt_field = mcc_pkg::AMT_W'($urandom);
      send_request(coin, i == n - 1, amt_field);
    end
  endtask

  initial begin
    int  n;
    int  amt;
    int  pick;
    bit  gaps;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // zero amount
    send_request(10'd5, 1'b1, 10'd0);
    // largest coin and largest amount
    send_request(10'd1023, 1'b1, 10'd1023);
    // widest count the field can hold
    send_request(10'd1, 1'b1, 10'd1023);
    // unreachable target
    send_request(10'd4, 1'b0, 10'd0);
    send_request(10'd6, 1'b1, 10'd7);
    // zero-valued coin
    send_request(10'd0, 1'b0, 10'd0);
    send_request(10'd3, 1'b1, 10'd9);
    // full store, last coin dropped
    for (int i = 0; i < mcc_pkg::MAX_COINS_DEF; i++) send_request(10'(i + 3), 1'b0, 10'd0);
    send_request(10'd1, 1'b1, 10'd1);
    hold_off(3);

    items_sent = 0;
    while (items_sent < 580) begin
      gaps = items_sent < 500;
      pick = $urandom_range(0, 99);
      if (pick < 8) n = $urandom_range(mcc_pkg::MAX_COINS_DEF + 1, mcc_pkg::MAX_COINS_DEF + 4);
      else n = $urandom_range(1, 6);
      pick = $urandom_range(0, 99);
      if (pick < 5) amt = 0;
      else if (pick < 88) amt = $urandom_range(1, 63);
      else if (pick < 97) amt = $urandom_range(64, 300);
      else amt = $urandom_range(301, 1023);
      send_set(n, amt, (amt < 8) ? 8 : amt / 2, gaps);
      if (gaps && $urandom_range(0, 2) == 0) hold_off($urandom_range(1, 11));
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (fail_count == 0) begin
      $display("min_coin_change_dp_core_tb passed");
    end else begin
      $display("min_coin_change_dp_core_tb failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
